// ===== rtl/core/xfys_pkg.sv =====
// xfys_pkg: field widths and generator constants of the xorshift shuffler
// no dependencies; used by the channel interfaces and the shuffler unit
package xfys_pkg;

  localparam int SeedW  = 32;
  localparam int CountW = 7;
  localparam int IdxW   = 6;

  localparam logic [SeedW-1:0] GoldenSeed = 32'h9E37_79B9;
  localparam int ShiftA = 13;
  localparam int ShiftB = 17;
  localparam int ShiftC = 5;

  typedef logic [SeedW-1:0]  seed_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [IdxW-1:0]   idx_t;

  function automatic seed_t xorshift32(input seed_t x);
    seed_t a;
    seed_t b;
    a = x ^ (x << ShiftA);
    b = a ^ (a >> ShiftB);
    return b ^ (b << ShiftC);
  endfunction

endpackage

// ===== rtl/core/xfys_if.sv =====
// xfys_in_if / xfys_out_if: valid/ready channels of the shuffler
// depends on xfys_pkg for payload types
interface xfys_in_if;
  import xfys_pkg::*;
  logic   valid;
  logic   ready;
  seed_t  seed;
  count_t entry_count;

  modport source (output valid, seed, entry_count, input ready);
  modport sink   (input valid, seed, entry_count, output ready);
endinterface

interface xfys_out_if;
  import xfys_pkg::*;
  logic valid;
  logic ready;
  idx_t position;
  idx_t entry;
  logic last;

  modport source (output valid, position, entry, last, input ready);
  modport sink   (input valid, position, entry, last, output ready);
endinterface

// ===== rtl/core/xorshift_fisher_yates_shuffler_unit.sv =====
// xorshift_fisher_yates_shuffler_unit: fills an order store, shuffles it with a
// xorshift32-driven Fisher-Yates pass and streams the permutation; uses xfys_pkg, xfys_if
// sequence: a fill pass, then per swap a generator step, the bit-serial remainder unit,
//   one read and two write-backs over the single write port, then per result a
//   registered memory read and the output register
// throughput: one session at a time, a new start is taken once the last result transfers
// reset: asynchronous, clears control, generator and counters; the order store is not reset
module xorshift_fisher_yates_shuffler_unit #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  xfys_in_if.sink             in_i,
  xfys_out_if.source          out_o
);
  import xfys_pkg::*;

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int EW = (CW > CountW) ? CW : CountW;
  localparam int BW = $clog2(SeedW);
  localparam logic [EW-1:0] MaxCount = EW'(MAX_ENTRIES);

  localparam logic [3:0] StIdle    = 4'd0;
  localparam logic [3:0] StFill    = 4'd1;
  localparam logic [3:0] StRng     = 4'd2;
  localparam logic [3:0] StMod     = 4'd3;
  localparam logic [3:0] StSwapRd  = 4'd4;
  localparam logic [3:0] StSwapWh  = 4'd5;
  localparam logic [3:0] StSwapWj  = 4'd6;
  localparam logic [3:0] StEmitRd  = 4'd7;
  localparam logic [3:0] StEmitOut = 4'd8;

  logic [3:0]    state_q, state_d;
  seed_t         rng_q, rng_d;
  seed_t         dvd_q, dvd_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [BW-1:0] bit_q, bit_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [CW-1:0] i_q, i_d;
  logic          out_valid_q, out_valid_d;
  logic          last_q, last_d;

  logic [AW-1:0] order_mem [MAX_ENTRIES];
  logic [AW-1:0] rd_a_q, rd_b_q;
  logic [AW-1:0] rd_a_addr, rd_b_addr;
  logic          rd_en;
  logic          we;
  logic [AW-1:0] wa, wd;

  logic [EW-1:0] cnt_ext, cnt_sat;
  logic [CW:0]   trial;
  logic [CW:0]   trial_sub;
  logic [AW-1:0] hi_addr, j_addr;
  logic [AW+IdxW-1:0] pos_ext, entry_ext;

  assign cnt_ext   = EW'(in_i.entry_count);
  assign cnt_sat   = (cnt_ext > MaxCount) ? MaxCount : cnt_ext;
  assign hi_addr   = AW'(i_q - 1'b1);
  assign j_addr    = rem_q[AW-1:0];
  assign trial     = {rem_q, dvd_q[SeedW-1]};
  assign trial_sub = trial - {1'b0, i_q};

  always_comb begin
    state_d     = state_q;
    rng_d       = rng_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    bit_d       = bit_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    i_d         = i_q;
    out_valid_d = out_valid_q;
    last_d      = last_q;
    rd_en       = 1'b0;
    rd_a_addr   = pos_q[AW-1:0];
    rd_b_addr   = j_addr;
    we          = 1'b0;
    wa          = pos_q[AW-1:0];
    wd          = pos_q[AW-1:0];
    unique case (state_q)
      StIdle: begin
        if (in_i.valid) begin
          rng_d = (in_i.seed != '0) ? in_i.seed : GoldenSeed;
          cnt_d = cnt_sat[CW-1:0];
          pos_d = '0;
          if (cnt_sat != '0) state_d = StFill;
        end
      end
      StFill: begin
        we = 1'b1;
        if (pos_q == CW'(cnt_q - 1'b1)) begin
          pos_d = '0;
          i_d   = cnt_q;
          state_d = (cnt_q > CW'(1)) ? StRng : StEmitRd;
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end
      StRng: begin
        rng_d   = xorshift32(rng_q);
        dvd_d   = xorshift32(rng_q);
        rem_d   = '0;
        bit_d   = '0;
        state_d = StMod;
      end
      StMod: begin
        rem_d = trial_sub[CW] ? trial[CW-1:0] : trial_sub[CW-1:0];
        dvd_d = dvd_q << 1;
        bit_d = bit_q + 1'b1;
        if (bit_q == BW'(SeedW - 1)) state_d = StSwapRd;
      end
      StSwapRd: begin
        rd_en     = 1'b1;
        rd_a_addr = hi_addr;
        state_d   = StSwapWh;
      end
      StSwapWh: begin
        we      = 1'b1;
        wa      = hi_addr;
        wd      = rd_b_q;
        state_d = StSwapWj;
      end
      StSwapWj: begin
        we  = 1'b1;
        wa  = j_addr;
        wd  = rd_a_q;
        i_d = i_q - 1'b1;
        state_d = (i_q == CW'(2)) ? StEmitRd : StRng;
      end
      StEmitRd: begin
        rd_en       = 1'b1;
        last_d      = (pos_q == CW'(cnt_q - 1'b1));
        out_valid_d = 1'b1;
        state_d     = StEmitOut;
      end
      StEmitOut: begin
        if (out_o.ready) begin
          out_valid_d = 1'b0;
          if (last_q) begin
            state_d = StIdle;
          end else begin
            pos_d   = pos_q + 1'b1;
            state_d = StEmitRd;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rng_q       <= '0;
      cnt_q       <= '0;
      pos_q       <= '0;
      i_q         <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      rng_q       <= rng_d;
      cnt_q       <= cnt_d;
      pos_q       <= pos_d;
      i_q         <= i_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  // order store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we) order_mem[wa] <= wd;
    if (rd_en) begin
      rd_a_q <= order_mem[rd_a_addr];
      rd_b_q <= order_mem[rd_b_addr];
    end
  end

  assign pos_ext   = {{IdxW{1'b0}}, pos_q[AW-1:0]};
  assign entry_ext = {{IdxW{1'b0}}, rd_a_q};

  assign in_i.ready     = (state_q == StIdle);
  assign out_o.valid    = out_valid_q;
  assign out_o.position = pos_ext[IdxW-1:0];
  assign out_o.entry    = entry_ext[IdxW-1:0];
  assign out_o.last     = last_q;

endmodule

// ===== rtl/core/xfys_checker.sv =====
// xfys_checker: port-level checks of the shuffler unit, bound into the shuffler unit
// depends on xfys_pkg and xorshift_fisher_yates_shuffler_unit
module xfys_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input xfys_pkg::idx_t       position_i,
  input logic                 last_i
);
  import xfys_pkg::*;

  logic in_xfer, out_xfer;
  idx_t exp_pos_q;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  // expected position of the next result transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_pos_q <= '0;
    end else if (in_xfer || (out_xfer && last_i)) begin
      exp_pos_q <= '0;
    end else if (out_xfer) begin
      exp_pos_q <= exp_pos_q + 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before transfer");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("start taken while a result is pending");

  a_pos_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> position_i == exp_pos_q)
    else $error("positions out of order");

  a_busy_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && !last_i |=> !in_ready_i)
    else $error("start accepted before permutation complete");

endmodule

bind xorshift_fisher_yates_shuffler_unit xfys_checker u_xfys_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .position_i  (out_o.position),
  .last_i      (out_o.last)
);
